[sv/stb_pkg.sv]
package stb_pkg;

  // fraction bits of every sine/cosine quantity
  localparam int TRIG_FRAC_BITS = 16;
  // signed width of trig quantities: covers arguments up to about 16 radians
  localparam int TW  = TRIG_FRAC_BITS + 5;
  localparam int TW2 = 2 * TW;

  // field widths
  localparam int VAL_W = 32;
  localparam int ANG_W = 24;
  localparam int ANG_FRAC = 8;

  // scale product widths after dropping the trig fraction bits
  localparam int PW2 = VAL_W + TW;
  localparam int PW  = PW2 - TRIG_FRAC_BITS;

  // angle wrap: whole degrees are offset to stay nonnegative, then reduced mod 360
  localparam int TURN_DEG    = 360;
  localparam int WRAP_OFFSET = TURN_DEG * 92;
  localparam int U_W         = 17;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_M     = ((1 << RECIP_SHIFT) + TURN_DEG - 1) / TURN_DEG;
  localparam int QP_W        = 32;
  localparam int QUO_W       = 8;
  localparam int DEG_W       = 9;

  // pipeline depth
  localparam int SINE_LAT = 6;
  localparam int NSTG     = 4 + SINE_LAT + 2;

  // rounding bias for the fraction shift
  localparam int RND_HALF = 1 << (TRIG_FRAC_BITS - 1);

  typedef logic signed [TW-1:0]    trig_t;
  typedef logic signed [PW-1:0]    prod_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // fixed-point constants, rounded to nearest
  localparam longint unsigned C_D2R =
      ((64'd174533 << TRIG_FRAC_BITS) + 64'd5000000) / 64'd10000000;
  localparam longint unsigned C_PI =
      ((64'd31415 << TRIG_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned C_HALF_PI =
      ((64'd157075 << TRIG_FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam longint unsigned C_LIN =
      ((64'd40000 << TRIG_FRAC_BITS) + 64'd15707) / 64'd31415;
  localparam longint unsigned C_SQR =
      ((64'd400000000 << TRIG_FRAC_BITS) + 64'd493451112) / 64'd986902225;
  localparam longint unsigned C_REFINE =
      ((64'd9 << TRIG_FRAC_BITS) + 64'd20) / 64'd40;

  localparam trig_t K_D2R     = trig_t'(C_D2R);
  localparam trig_t K_PI      = trig_t'(C_PI);
  localparam trig_t K_NEG_PI  = trig_t'(-C_PI);
  localparam trig_t K_TWO_PI  = trig_t'(2 * C_PI);
  localparam trig_t K_HALF_PI = trig_t'(C_HALF_PI);
  localparam trig_t K_LIN     = trig_t'(C_LIN);
  localparam trig_t K_SQR     = trig_t'(C_SQR);
  localparam trig_t K_REFINE  = trig_t'(C_REFINE);

  localparam val_t SAT_MAX = 32'sh7fff_ffff;
  localparam val_t SAT_MIN = 32'sh8000_0000;

  // operands that travel alongside the angle math
  typedef struct packed {
    val_t pos_x;
    val_t pos_y;
    val_t scale_x;
    val_t scale_y;
  } carry_t;

  // trig product, rounded to nearest with ties away from zero
  function automatic trig_t mulq(trig_t a, trig_t b);
    logic signed [TW2-1:0] p;
    logic signed [TW2-1:0] bias;
    p = a * b;
    bias = p[TW2-1] ? TW2'(RND_HALF - 1) : TW2'(RND_HALF);
    return trig_t'((p + bias) >>> TRIG_FRAC_BITS);
  endfunction

  // scale times trig, same rounding, result kept wide for the clip
  function automatic prod_t mulq_out(val_t s, trig_t t);
    logic signed [PW2-1:0] p;
    logic signed [PW2-1:0] bias;
    p = s * t;
    bias = p[PW2-1] ? PW2'(RND_HALF - 1) : PW2'(RND_HALF);
    return prod_t'((p + bias) >>> TRIG_FRAC_BITS);
  endfunction

  // true when the value needs clipping to 32 bits
  function automatic logic over(prod_t v);
    return !((&v[PW-1:VAL_W-1]) || !(|v[PW-1:VAL_W-1]));
  endfunction

  function automatic val_t clip(prod_t v);
    val_t r;
    if (over(v)) begin
      r = v[PW-1] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/stb_in_if.sv]
interface stb_in_if;
  logic valid;
  logic ready;
  logic signed [stb_pkg::VAL_W-1:0] pos_x;
  logic signed [stb_pkg::VAL_W-1:0] pos_y;
  logic signed [stb_pkg::VAL_W-1:0] scale_x;
  logic signed [stb_pkg::VAL_W-1:0] scale_y;
  logic signed [stb_pkg::ANG_W-1:0] angle_deg;

  modport source (
    output valid, pos_x, pos_y, scale_x, scale_y, angle_deg,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, scale_x, scale_y, angle_deg,
    output ready
  );
endinterface

[sv/stb_out_if.sv]
interface stb_out_if;
  logic valid;
  logic ready;
  logic signed [stb_pkg::VAL_W-1:0] row0_col0;
  logic signed [stb_pkg::VAL_W-1:0] row0_col1;
  logic signed [stb_pkg::VAL_W-1:0] row1_col0;
  logic signed [stb_pkg::VAL_W-1:0] row1_col1;
  logic signed [stb_pkg::VAL_W-1:0] row3_col0;
  logic signed [stb_pkg::VAL_W-1:0] row3_col1;
  logic saturated;

  modport source (
    output valid, row0_col0, row0_col1, row1_col0, row1_col1, row3_col0, row3_col1,
    output saturated,
    input  ready
  );

  modport sink (
    input  valid, row0_col0, row0_col1, row1_col0, row1_col1, row3_col0, row3_col1,
    input  saturated,
    output ready
  );
endinterface

[sv/sprite_transform_builder_top.sv]
// throughput: one transaction per cycle; the whole 12-stage register chain advances
//   together whenever the output register is empty or its result is taken
// reset: rst (synchronous, active high) clears the stage valid bits only;
//   data registers hold whatever they had
module sprite_transform_builder_top (
  input logic       clk,
  input logic       rst,
  stb_in_if.sink    item,
  stb_out_if.source result
);

  localparam int LAST = stb_pkg::NSTG - 1;

  logic [stb_pkg::NSTG-1:0] vld;
  logic                     adv;

  stb_pkg::carry_t carry [stb_pkg::NSTG-1];

  // stage 1: offset whole degrees
  logic [stb_pkg::U_W-1:0] s1_u;
  logic                    s1_wrap;
  logic                    a_wrap;

  // stage 2: quotient by 360
  logic [stb_pkg::QP_W-1:0]  qp;
  logic [stb_pkg::U_W-1:0]   s2_u;
  logic [stb_pkg::QUO_W-1:0] s2_quo;
  logic                      s2_wrap;

  // stage 3: whole degrees in 0..360
  logic [stb_pkg::U_W-1:0]   quo_prod;
  logic [stb_pkg::U_W-1:0]   rem;
  logic [stb_pkg::U_W-1:0]   rem_c;
  logic [stb_pkg::DEG_W-1:0] deg;
  logic [stb_pkg::DEG_W-1:0] s3_deg;

  // stage 4: radians
  stb_pkg::trig_t s4_xs;
  stb_pkg::trig_t s4_xc;
  stb_pkg::trig_t sin_q;
  stb_pkg::trig_t cos_q;

  // stage 11: products
  stb_pkg::prod_t p00;
  stb_pkg::prod_t p01;
  stb_pkg::prod_t p10;
  stb_pkg::prod_t p11;
  stb_pkg::prod_t n10;

  // stage 12: output register
  stb_pkg::val_t o00;
  stb_pkg::val_t o01;
  stb_pkg::val_t o10;
  stb_pkg::val_t o11;
  stb_pkg::val_t o30;
  stb_pkg::val_t o31;
  logic          o_sat;

  // whole pipe moves when the output register frees up
  assign adv        = !vld[LAST] || result.ready;
  assign item.ready = adv;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], item.valid};
    end
  end

  // positive exact multiple of a full turn maps to 360, not 0
  assign a_wrap = !item.angle_deg[stb_pkg::ANG_W-1] && (item.angle_deg != '0)
                  && (item.angle_deg[stb_pkg::ANG_FRAC-1:0] == '0);

  assign qp = stb_pkg::QP_W'(s1_u) * stb_pkg::QP_W'(stb_pkg::RECIP_M);

  // remainder with one correction step
  always_comb begin
    quo_prod = stb_pkg::U_W'(s2_quo) * stb_pkg::U_W'(stb_pkg::TURN_DEG);
    rem      = s2_u - quo_prod;
    rem_c    = (rem >= stb_pkg::U_W'(stb_pkg::TURN_DEG)) ?
               rem - stb_pkg::U_W'(stb_pkg::TURN_DEG) : rem;
    deg      = ((rem_c == '0) && s2_wrap) ? stb_pkg::DEG_W'(stb_pkg::TURN_DEG) :
               stb_pkg::DEG_W'(rem_c);
  end

  // angle path and operand carry
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u    <= stb_pkg::U_W'({item.angle_deg[stb_pkg::ANG_W-1],
                                item.angle_deg[stb_pkg::ANG_W-1:stb_pkg::ANG_FRAC]})
                 + stb_pkg::U_W'(stb_pkg::WRAP_OFFSET);
      s1_wrap <= a_wrap;
      carry[0] <= '{pos_x: item.pos_x, pos_y: item.pos_y,
                    scale_x: item.scale_x, scale_y: item.scale_y};
      for (int i = 1; i < stb_pkg::NSTG - 1; i++) begin
        carry[i] <= carry[i-1];
      end
      s2_u    <= s1_u;
      s2_quo  <= qp[stb_pkg::RECIP_SHIFT+stb_pkg::QUO_W-1:stb_pkg::RECIP_SHIFT];
      s2_wrap <= s1_wrap;
      s3_deg  <= deg;
      s4_xs   <= stb_pkg::trig_t'({1'b0, s3_deg}) * stb_pkg::K_D2R;
      s4_xc   <= stb_pkg::trig_t'(stb_pkg::trig_t'({1'b0, s3_deg}) * stb_pkg::K_D2R)
                 + stb_pkg::K_HALF_PI;
    end
  end

  // sine and cosine units
  stb_sine u_sin (
    .clk  (clk),
    .en   (adv),
    .arg  (s4_xs),
    .sine (sin_q)
  );

  stb_sine u_cos (
    .clk  (clk),
    .en   (adv),
    .arg  (s4_xc),
    .sine (cos_q)
  );

  assign n10 = -p10;

  // scale products, then clip into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      p00   <= stb_pkg::mulq_out(carry[LAST-2].scale_x, cos_q);
      p01   <= stb_pkg::mulq_out(carry[LAST-2].scale_x, sin_q);
      p10   <= stb_pkg::mulq_out(carry[LAST-2].scale_y, sin_q);
      p11   <= stb_pkg::mulq_out(carry[LAST-2].scale_y, cos_q);
      o00   <= stb_pkg::clip(p00);
      o01   <= stb_pkg::clip(p01);
      o10   <= stb_pkg::clip(n10);
      o11   <= stb_pkg::clip(p11);
      o30   <= carry[LAST-1].pos_x;
      o31   <= carry[LAST-1].pos_y;
      o_sat <= stb_pkg::over(p00) || stb_pkg::over(p01) ||
               stb_pkg::over(n10) || stb_pkg::over(p11);
    end
  end

  assign result.valid     = vld[LAST];
  assign result.row0_col0 = o00;
  assign result.row0_col1 = o01;
  assign result.row1_col0 = o10;
  assign result.row1_col1 = o11;
  assign result.row3_col0 = o30;
  assign result.row3_col1 = o31;
  assign result.saturated = o_sat;

`ifndef SYNTHESIS
  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  // wrapped angle stays within one turn
  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (s3_deg <= stb_pkg::DEG_W'(stb_pkg::TURN_DEG)))
    else $error("wrapped degrees out of range");

  // a stall holds every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");

  // a clipped result shows at least one extreme entry
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturated) |->
      (result.row0_col0 == stb_pkg::SAT_MAX || result.row0_col0 == stb_pkg::SAT_MIN ||
       result.row0_col1 == stb_pkg::SAT_MAX || result.row0_col1 == stb_pkg::SAT_MIN ||
       result.row1_col0 == stb_pkg::SAT_MAX || result.row1_col0 == stb_pkg::SAT_MIN ||
       result.row1_col1 == stb_pkg::SAT_MAX || result.row1_col1 == stb_pkg::SAT_MIN))
    else $error("saturated flag without a clipped entry");
`endif

endmodule

[sv/stb_sine.sv]
module stb_sine (
  input  logic           clk,
  input  logic           en,
  input  stb_pkg::trig_t arg,
  output stb_pkg::trig_t sine
);

  stb_pkg::trig_t a0;
  stb_pkg::trig_t a1;
  stb_pkg::trig_t f_arg;
  stb_pkg::trig_t f_abs;
  stb_pkg::trig_t t_arg;
  stb_pkg::trig_t t_sqr;
  stb_pkg::trig_t y1;
  stb_pkg::trig_t y1_abs;
  stb_pkg::trig_t y2;
  stb_pkg::trig_t q2;
  stb_pkg::trig_t y3;
  stb_pkg::trig_t r3;

  // fold the argument into (-pi, pi]
  always_comb begin
    a0 = (arg >= stb_pkg::K_PI) ? arg - stb_pkg::K_TWO_PI : arg;
    a1 = (a0 <= stb_pkg::K_NEG_PI) ? a0 + stb_pkg::K_TWO_PI : a0;
    y1_abs = y1[stb_pkg::TW-1] ? -y1 : y1;
  end

  // parabola, then the refinement step, at most one product per stage
  always_ff @(posedge clk) begin
    if (en) begin
      f_arg <= a1;
      f_abs <= a1[stb_pkg::TW-1] ? -a1 : a1;
      t_arg <= f_arg;
      t_sqr <= stb_pkg::mulq(f_abs, stb_pkg::K_SQR);
      y1    <= stb_pkg::mulq(t_arg, stb_pkg::K_LIN - t_sqr);
      y2    <= y1;
      q2    <= stb_pkg::mulq(y1, y1_abs) - y1;
      y3    <= y2;
      r3    <= stb_pkg::mulq(q2, stb_pkg::K_REFINE);
      sine  <= y3 + r3;
    end
  end

endmodule

[verif/transform_checker.sv]
module transform_checker (
  input  logic clk,
  input  logic rst,
  stb_in_if    item,
  stb_out_if   result,
  output int   mismatches,
  output int   pending,
  output int   checked,
  output int   clipped
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = stb_pkg::TRIG_FRAC_BITS;

  // one full turn in Q8 degrees
  localparam longint FULL_TURN = 64'sd92160;

  // trig constants with FB fraction bits, rounded to nearest
  localparam longint D2R_Q     = ((64'sd174533 <<< FB) + 64'sd5000000) / 64'sd10000000;
  localparam longint PI_Q      = ((64'sd31415 <<< FB) + 64'sd5000) / 64'sd10000;
  localparam longint HALF_PI_Q = ((64'sd157075 <<< FB) + 64'sd50000) / 64'sd100000;
  localparam longint LIN_Q     = ((64'sd40000 <<< FB) + 64'sd15707) / 64'sd31415;
  localparam longint SQR_Q     = ((64'sd400000000 <<< FB) + 64'sd493451112) / 64'sd986902225;
  localparam longint REFINE_Q  = ((64'sd9 <<< FB) + 64'sd20) / 64'sd40;

  localparam longint TOP32 = 64'sd2147483647;
  localparam longint BOT32 = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] row0_col0;
    logic signed [31:0] row0_col1;
    logic signed [31:0] row1_col0;
    logic signed [31:0] row1_col1;
    logic signed [31:0] row3_col0;
    logic signed [31:0] row3_col1;
    logic               saturated;
  } matrix_t;

  matrix_t expected_q[$];

  // product with FB fraction bits dropped, rounded half away from zero
  function automatic longint round_mul(longint a, longint b);
    longint p;
    longint mag;
    longint r;
    p = a * b;
    mag = (p < 0) ? -p : p;
    r = (mag + (64'sd1 <<< (FB - 1))) >>> FB;
    return (p < 0) ? -r : r;
  endfunction

  // folded parabolic sine with the refinement pass
  function automatic longint parabolic_sine(longint arg);
    longint folded;
    longint y;
    longint corr;
    folded = arg;
    if (folded >= PI_Q) folded = folded - 2 * PI_Q;
    if (folded <= -PI_Q) folded = folded + 2 * PI_Q;
    y = round_mul(folded, LIN_Q - round_mul((folded < 0) ? -folded : folded, SQR_Q));
    corr = round_mul(y, (y < 0) ? -y : y) - y;
    return y + round_mul(corr, REFINE_Q);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > TOP32) return 32'sh7fff_ffff;
    if (v < BOT32) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // matrix entries for one sprite transaction
  function automatic matrix_t predict_transform(logic signed [31:0] px, logic signed [31:0] py,
                                                logic signed [31:0] sx, logic signed [31:0] sy,
                                                logic signed [23:0] ang);
    longint turn_rem;
    longint rad;
    longint sin_q;
    longint cos_q;
    longint prod [4];
    longint sxl;
    longint syl;
    matrix_t m;
    // wrap into [0, 360], exact positive multiples land on 360
    turn_rem = longint'(ang) % FULL_TURN;
    if (turn_rem < 0) begin
      turn_rem = turn_rem + FULL_TURN;
    end else if (turn_rem == 0 && ang > 0) begin
      turn_rem = FULL_TURN;
    end
    rad = (turn_rem / 256) * D2R_Q;
    sin_q = parabolic_sine(rad);
    cos_q = parabolic_sine(rad + HALF_PI_Q);
    sxl = sx;
    syl = sy;
    prod[0] = round_mul(sxl, cos_q);
    prod[1] = round_mul(sxl, sin_q);
    prod[2] = -round_mul(syl, sin_q);
    prod[3] = round_mul(syl, cos_q);
    m.saturated = 1'b0;
    foreach (prod[i]) begin
      if (prod[i] > TOP32 || prod[i] < BOT32) m.saturated = 1'b1;
    end
    m.row0_col0 = clamp32(prod[0]);
    m.row0_col1 = clamp32(prod[1]);
    m.row1_col0 = clamp32(prod[2]);
    m.row1_col1 = clamp32(prod[3]);
    m.row3_col0 = px;
    m.row3_col1 = py;
    return m;
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    matrix_t want;
    if (!rst) begin
      if (item.valid && item.ready) begin
        expected_q.push_back(predict_transform(item.pos_x, item.pos_y, item.scale_x,
                                               item.scale_y, item.angle_deg));
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no transform outstanding");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          mismatches += field_diff("row0_col0", want.row0_col0, result.row0_col0);
          mismatches += field_diff("row0_col1", want.row0_col1, result.row0_col1);
          mismatches += field_diff("row1_col0", want.row1_col0, result.row1_col0);
          mismatches += field_diff("row1_col1", want.row1_col1, result.row1_col1);
          mismatches += field_diff("row3_col0", want.row3_col0, result.row3_col0);
          mismatches += field_diff("row3_col1", want.row3_col1, result.row3_col1);
          mismatches += field_diff("saturated", 32'(want.saturated), 32'(result.saturated));
          checked++;
          if (want.saturated) clipped++;
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

[verif/sprite_transform_builder_top_tb.sv]
module sprite_transform_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 100;
  localparam int DRAIN       = 40;
  localparam int PHASE_ITEMS = 440;
  localparam int BURST_ITEMS = 60;

  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
  localparam int DEG = 256;

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_go;
  int   sent;
  int   cycle_count;
  int   mismatches;
  int   pending;
  int   checked;
  int   clipped;

  stb_in_if  item_if ();
  stb_out_if result_if ();

  sprite_transform_builder_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  transform_checker chk (
    .clk        (clk),
    .rst        (rst),
    .item       (item_if),
    .result     (result_if),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .clipped    (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output back-pressure, with a long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (hold_go) begin
        hold_go = 1'b0;
        stall_left = LONG_HOLD;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one transaction and hold it until accepted
  task automatic offer(input logic signed [31:0] px, input logic signed [31:0] py,
                       input logic signed [31:0] sx, input logic signed [31:0] sy,
                       input logic signed [23:0] ang);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid     <= 1'b1;
    item_if.pos_x     <= px;
    item_if.pos_y     <= py;
    item_if.scale_x   <= sx;
    item_if.scale_y   <= sy;
    item_if.angle_deg <= ang;
    do @(posedge clk); while (!item_if.ready);
    sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_scale();
    case ($urandom_range(5))
      0, 1: return $urandom();
      2, 3: return int'($urandom_range(1 << 19)) - (1 << 18);
      4: begin
        case ($urandom_range(4))
          0: return S_MAX;
          1: return S_MIN;
          2: return 32'sh0;
          3: return ONE_Q;
          default: return -ONE_Q;
        endcase
      end
      // just inside the range, where products clip easily
      default: return ($urandom_range(1) ? 32'sh7fff_0000 : 32'sh8000_0000)
                      + int'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic signed [23:0] pick_angle();
    logic [31:0] u;
    u = $urandom();
    case ($urandom_range(4))
      0: return u[23:0];
      1: return 24'(int'($urandom_range(6 * 92160)) - 3 * 92160);
      // exact multiples of a turn
      2: return 24'((int'($urandom_range(182)) - 91) * 92160);
      3: return 24'((int'($urandom_range(1439)) - 720) * DEG);
      default: return 24'(int'($urandom_range(359)) * DEG + int'($urandom_range(255)));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_pos();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_items(input int count);
    repeat (count) offer(pick_pos(), pick_pos(), pick_scale(), pick_scale(), pick_angle());
  endtask

  initial begin
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go = 1'b0;
    rst <= 1'b1;
    item_if.valid     <= 1'b0;
    item_if.pos_x     <= '0;
    item_if.pos_y     <= '0;
    item_if.scale_x   <= '0;
    item_if.scale_y   <= '0;
    item_if.angle_deg <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: quadrants, wrap corners, field extremes, clipping
    offer(0, 0, 0, 0, 0);
    offer(ONE_Q, -ONE_Q, ONE_Q, ONE_Q, 0);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 90 * DEG);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 180 * DEG);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 270 * DEG);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 360 * DEG);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 720 * DEG);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, -360 * DEG);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, -90 * DEG);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 45 * DEG + 128);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, -1);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 24'sh7f_ffff);
    offer(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 24'sh80_0000);
    offer(S_MAX, S_MAX, S_MAX, S_MAX, 0);
    offer(S_MIN, S_MIN, S_MIN, S_MIN, 0);
    offer(S_MAX, S_MIN, S_MIN, S_MIN, 90 * DEG);
    offer(S_MIN, S_MAX, S_MAX, S_MAX, 270 * DEG);
    offer(S_MAX, S_MIN, 0, 0, 30 * DEG);
    offer(S_MIN, S_MAX, -ONE_Q, -ONE_Q, 30 * DEG);
    offer(1, -1, 1, 1, DEG);
    offer(-1, 1, -1, -1, 359 * DEG + 255);
    offer(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0004_0000, -32'sh0004_0000, 135 * DEG);
    wait_drained();

    // sender mostly offering, receiver often not ready
    tx_idle_pct = 12;
    rx_idle_pct = 46;
    random_items(PHASE_ITEMS);
    wait_drained();

    // sender often idle, receiver mostly ready
    tx_idle_pct = 46;
    rx_idle_pct = 12;
    random_items(PHASE_ITEMS);
    wait_drained();

    // full rate, with a long output hold to back the pipeline up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go = 1'b1;
    random_items(BURST_ITEMS);
    random_items(PHASE_ITEMS - BURST_ITEMS);

    wait_drained();
    repeat (DRAIN) @(posedge clk);

    $display("%0d transforms offered: directed wrap and clipping corners, then random",
             sent);
    $display("items under three flow mixes plus a long output hold; %0d checked, %0d clipped",
             checked, clipped);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
